// ===== rtl/core/assert_macros.svh =====
// assertion macros for the segmenter rtl
// used by the top level, expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define UBFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// next-cycle implication, checked outside reset
`define UBFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/ubfs_pkg.sv =====
// shared types and constants for the usb bulk frame segmenter
// no dependencies
`default_nettype none

package ubfs_pkg;

  localparam int OP_W         = 3;
  localparam int ADDR_W       = 32;
  localparam int LEN_W        = 11;
  localparam int XLEN_W       = 7;
  localparam int PACKET_BYTES = 64;
  localparam int FRAME_MAX    = 1536;

  typedef enum logic [OP_W-1:0] {
    OP_POST_SEND = 3'd0,
    OP_POST_RECV = 3'd1,
    OP_POP_SEND  = 3'd2,
    OP_POP_RECV  = 3'd3,
    OP_TX_SLOT   = 3'd4,
    OP_RX_PACKET = 3'd5,
    OP_BUS_RESET = 3'd6
  } op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // one frame buffer descriptor: start address, length or capacity, bytes done
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  cur;
  } desc_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ubfs_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/ubfs_ram.sv =====
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module ubfs_ram #(
  parameter int WIDTH = 54,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/ubfs_ctrl.sv =====
// controller fsm: accepts a word, then runs its execute state
// depends on ubfs_pkg
`default_nettype none

module ubfs_ctrl
  import ubfs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output      logic busy,
  output      ubfs_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    case (state_r)
      ST_IDLE: begin
        state_nxt = start ? ST_EXEC : ST_IDLE;
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy     = 1'b0;
    cmd.load = 1'b0;
    cmd.exec = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cmd.load = start;
      end
      ST_EXEC: begin
        busy     = 1'b1;
        cmd.exec = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/ubfs_datapath.sv =====
// datapath: ring pointers, descriptor rams, flags and result registers
// depends on ubfs_pkg and ubfs_ram
`default_nettype none

module ubfs_datapath
  import ubfs_pkg::*;
#(
  parameter int RING_DEPTH = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ubfs_cmd_t         cmd,
  input  wire logic [OP_W-1:0]   in_operation,
  input  wire logic [ADDR_W-1:0] in_buf_addr,
  input  wire logic [LEN_W-1:0]  in_buf_length,
  input  wire logic [XLEN_W-1:0] in_packet_length,
  input  wire logic              in_endpoint_busy,
  output      logic              out_valid,
  output      logic              out_accepted,
  output      logic              out_pop_valid,
  output      logic [LEN_W-1:0]  out_popped_length,
  output      logic              out_xfer_valid,
  output      logic [ADDR_W-1:0] out_xfer_addr,
  output      logic [XLEN_W-1:0] out_xfer_length,
  output      logic              out_frame_done,
  output      logic              out_nak_enable
);

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  localparam logic [LEN_W-1:0]  PKT_LEN  = LEN_W'(PACKET_BYTES);
  localparam logic [XLEN_W-1:0] PKT_XLEN = XLEN_W'(PACKET_BYTES);
  localparam logic [LEN_W-1:0]  MAX_LEN  = LEN_W'(FRAME_MAX);
  localparam logic [SUM_W-1:0]  DEPTH_S  = SUM_W'(RING_DEPTH);

  typedef struct packed {
    logic [IDX_W-1:0] oldest;
    logic [CNT_W-1:0] done;
    logic [CNT_W-1:0] active;
  } ptr_t;

  // operands are below twice the depth, so one subtract wraps them
  function automatic logic [IDX_W-1:0] wrap(input logic [SUM_W-1:0] v);
    logic [SUM_W-1:0] w;
    w = (v >= DEPTH_S) ? v - DEPTH_S : v;
    return w[IDX_W-1:0];
  endfunction

  ptr_t s_ptr_r, s_ptr_nxt, r_ptr_r, r_ptr_nxt;
  logic drop_r, drop_nxt, nak_r, nak_nxt;

  op_t               op_r;
  logic [ADDR_W-1:0] baddr_r;
  logic [LEN_W-1:0]  blen_r;
  logic [XLEN_W-1:0] plen_r;
  logic              epb_r;

  logic              valid_r, acc_r, acc_nxt, popv_r, popv_nxt, xv_r, xv_nxt;
  logic              fdone_r, fdone_nxt;
  logic [LEN_W-1:0]  popl_r, popl_nxt;
  logic [ADDR_W-1:0] xaddr_r, xaddr_nxt;
  logic [XLEN_W-1:0] xlen_r, xlen_nxt;

  logic [IDX_W-1:0]  s_head, r_head, s_tail, r_tail, s_raddr, r_raddr;
  logic              s_full, r_full;
  logic              s_we, r_we;
  logic [IDX_W-1:0]  s_waddr, r_waddr;
  desc_t             s_wdata, r_wdata, s_q, r_q;
  logic [$bits(desc_t)-1:0] s_qbits, r_qbits;

  logic [LEN_W-1:0]  len_sat;
  logic [LEN_W-1:0]  s_left, r_left, s_cur_new, r_cur_new;
  logic [XLEN_W-1:0] s_n, r_pk, r_room, r_got;
  logic [ADDR_W-1:0] s_xaddr, r_xaddr;

  assign s_head = wrap(SUM_W'(s_ptr_r.oldest) + SUM_W'(s_ptr_r.done));
  assign r_head = wrap(SUM_W'(r_ptr_r.oldest) + SUM_W'(r_ptr_r.done));
  assign s_tail = wrap(SUM_W'(s_ptr_r.oldest) + SUM_W'(s_ptr_r.done)
                       + SUM_W'(s_ptr_r.active));
  assign r_tail = wrap(SUM_W'(r_ptr_r.oldest) + SUM_W'(r_ptr_r.done)
                       + SUM_W'(r_ptr_r.active));
  assign s_full = (SUM_W'(s_ptr_r.done) + SUM_W'(s_ptr_r.active)) >= DEPTH_S;
  assign r_full = (SUM_W'(r_ptr_r.done) + SUM_W'(r_ptr_r.active)) >= DEPTH_S;

  // pops read the oldest slot, everything else the head active buffer
  assign s_raddr = (in_operation == OP_POP_SEND) ? s_ptr_r.oldest : s_head;
  assign r_raddr = (in_operation == OP_POP_RECV) ? r_ptr_r.oldest : r_head;

  ubfs_ram #(.WIDTH($bits(desc_t)), .DEPTH(RING_DEPTH)) u_send_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_qbits)
  );

  ubfs_ram #(.WIDTH($bits(desc_t)), .DEPTH(RING_DEPTH)) u_recv_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (r_waddr),
    .wdata (r_wdata),
    .raddr (r_raddr),
    .rdata (r_qbits)
  );

  assign s_q = desc_t'(s_qbits);
  assign r_q = desc_t'(r_qbits);

  assign len_sat = (blen_r > MAX_LEN) ? MAX_LEN : blen_r;

  // send: next piece of the head frame, at most one packet
  assign s_left    = (s_q.len > s_q.cur) ? s_q.len - s_q.cur : '0;
  assign s_n       = (s_left < PKT_LEN) ? s_left[XLEN_W-1:0] : PKT_XLEN;
  assign s_cur_new = s_q.cur + LEN_W'(s_n);
  assign s_xaddr   = s_q.addr + ADDR_W'(s_q.cur);

  // receive: packet clamped to the room left in the head buffer
  assign r_pk      = (plen_r > PKT_XLEN) ? PKT_XLEN : plen_r;
  assign r_left    = (r_q.len > r_q.cur) ? r_q.len - r_q.cur : '0;
  assign r_room    = (r_left < PKT_LEN) ? r_left[XLEN_W-1:0] : PKT_XLEN;
  assign r_got     = (r_pk < r_room) ? r_pk : r_room;
  assign r_cur_new = r_q.cur + LEN_W'(r_got);
  assign r_xaddr   = r_q.addr + ADDR_W'(r_q.cur);

  always_comb begin
    s_ptr_nxt = s_ptr_r;
    r_ptr_nxt = r_ptr_r;
    drop_nxt  = drop_r;
    nak_nxt   = nak_r;
    s_we      = 1'b0;
    r_we      = 1'b0;
    s_waddr   = s_head;
    r_waddr   = r_head;
    s_wdata   = s_q;
    r_wdata   = r_q;
    acc_nxt   = 1'b0;
    popv_nxt  = 1'b0;
    popl_nxt  = '0;
    xv_nxt    = 1'b0;
    xaddr_nxt = '0;
    xlen_nxt  = '0;
    fdone_nxt = 1'b0;
    if (cmd.exec) begin
      case (op_r)
        OP_POST_SEND: begin
          if (!s_full) begin
            s_we             = 1'b1;
            s_waddr          = s_tail;
            s_wdata.addr     = baddr_r;
            s_wdata.len      = len_sat;
            s_wdata.cur      = '0;
            s_ptr_nxt.active = s_ptr_r.active + 1'b1;
            nak_nxt          = 1'b1;
            acc_nxt          = 1'b1;
          end
        end
        OP_POST_RECV: begin
          if (!r_full) begin
            r_we             = 1'b1;
            r_waddr          = r_tail;
            r_wdata.addr     = baddr_r;
            r_wdata.len      = len_sat;
            r_wdata.cur      = '0;
            r_ptr_nxt.active = r_ptr_r.active + 1'b1;
            acc_nxt          = 1'b1;
          end
        end
        OP_POP_SEND: begin
          if (s_ptr_r.done != '0) begin
            popv_nxt         = 1'b1;
            popl_nxt         = s_q.cur;
            s_ptr_nxt.oldest = wrap(SUM_W'(s_ptr_r.oldest) + SUM_W'(1));
            s_ptr_nxt.done   = s_ptr_r.done - 1'b1;
          end
        end
        OP_POP_RECV: begin
          if (r_ptr_r.done != '0) begin
            popv_nxt         = 1'b1;
            popl_nxt         = r_q.cur;
            r_ptr_nxt.oldest = wrap(SUM_W'(r_ptr_r.oldest) + SUM_W'(1));
            r_ptr_nxt.done   = r_ptr_r.done - 1'b1;
          end
        end
        OP_TX_SLOT: begin
          if (s_ptr_r.active == '0) begin
            nak_nxt = 1'b0;
          end else if (!epb_r) begin
            s_we        = 1'b1;
            s_wdata.cur = s_cur_new;
            xv_nxt      = 1'b1;
            xaddr_nxt   = s_xaddr;
            xlen_nxt    = s_n;
            // a short or zero-length packet ends the frame
            if (s_cur_new >= s_q.len && s_n < PKT_XLEN) begin
              s_ptr_nxt.active = s_ptr_r.active - 1'b1;
              s_ptr_nxt.done   = s_ptr_r.done + 1'b1;
              fdone_nxt        = 1'b1;
            end
          end
        end
        OP_RX_PACKET: begin
          if (r_ptr_r.active == '0 || drop_r) begin
            // discard until the next short packet
            drop_nxt = !(r_pk < PKT_XLEN);
          end else begin
            r_we        = 1'b1;
            r_wdata.cur = r_cur_new;
            xv_nxt      = 1'b1;
            xaddr_nxt   = r_xaddr;
            xlen_nxt    = r_got;
            if (r_got < PKT_XLEN) begin
              r_ptr_nxt.active = r_ptr_r.active - 1'b1;
              r_ptr_nxt.done   = r_ptr_r.done + 1'b1;
              fdone_nxt        = 1'b1;
            end
          end
        end
        OP_BUS_RESET: begin
          drop_nxt = 1'b0;
          if (r_ptr_r.active != '0) begin
            r_we        = 1'b1;
            r_wdata.cur = '0;
          end
          if (s_ptr_r.active != '0) begin
            s_we        = 1'b1;
            s_wdata.cur = '0;
          end
          nak_nxt = (s_ptr_r.active != '0);
        end
        default: begin
          drop_nxt = drop_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_ptr_r <= '0;
      r_ptr_r <= '0;
      drop_r  <= 1'b0;
      nak_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      s_ptr_r <= s_ptr_nxt;
      r_ptr_r <= r_ptr_nxt;
      drop_r  <= drop_nxt;
      nak_r   <= nak_nxt;
      valid_r <= cmd.exec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= op_t'(in_operation);
      baddr_r <= in_buf_addr;
      blen_r  <= in_buf_length;
      plen_r  <= in_packet_length;
      epb_r   <= in_endpoint_busy;
    end
    if (cmd.exec) begin
      acc_r   <= acc_nxt;
      popv_r  <= popv_nxt;
      popl_r  <= popl_nxt;
      xv_r    <= xv_nxt;
      xaddr_r <= xaddr_nxt;
      xlen_r  <= xlen_nxt;
      fdone_r <= fdone_nxt;
    end
  end

  assign out_valid         = valid_r;
  assign out_accepted      = acc_r;
  assign out_pop_valid     = popv_r;
  assign out_popped_length = popl_r;
  assign out_xfer_valid    = xv_r;
  assign out_xfer_addr     = xaddr_r;
  assign out_xfer_length   = xlen_r;
  assign out_frame_done    = fdone_r;
  assign out_nak_enable    = nak_r;

endmodule

`default_nettype wire

// ===== rtl/core/usb_bulk_frame_segmenter_top.sv =====
// usb bulk frame segmenter: send and receive descriptor rings with
// 64-byte bulk packet segmentation and zero-length packet handling.
//
// usage:
//   raise start with an operation on the in_ ports; the word is taken at
//   the edge where start is high and busy is low. operations post a send
//   or receive buffer, pop a completed buffer, serve a tx slot, take a
//   received packet, or apply a bus reset.
//   exactly one result per word appears on the out_ ports for one cycle,
//   marked by out_valid. the receiver cannot stall, so nothing waits.
//   the accepting edge loads the word and registers the descriptor ram
//   read; the execute state does the read-modify-write and registers the
//   result. busy is high in that state, so no new word is taken then.
//   out_nak_enable shows the send nak enable at all times.
//   reset (rst_n low, synchronous) empties both rings and clears the
//   dropping and nak flags; descriptor contents are not cleared.
// depends on ubfs_pkg, ubfs_ctrl, ubfs_datapath, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module usb_bulk_frame_segmenter_top
  import ubfs_pkg::*;
#(
  parameter int RING_DEPTH = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output      logic              busy,
  input  wire logic [OP_W-1:0]   in_operation,
  input  wire logic [ADDR_W-1:0] in_buf_addr,
  input  wire logic [LEN_W-1:0]  in_buf_length,
  input  wire logic [XLEN_W-1:0] in_packet_length,
  input  wire logic              in_endpoint_busy,
  output      logic              out_valid,
  output      logic              out_accepted,
  output      logic              out_pop_valid,
  output      logic [LEN_W-1:0]  out_popped_length,
  output      logic              out_xfer_valid,
  output      logic [ADDR_W-1:0] out_xfer_addr,
  output      logic [XLEN_W-1:0] out_xfer_length,
  output      logic              out_frame_done,
  output      logic              out_nak_enable
);

  ubfs_cmd_t cmd;

  ubfs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  ubfs_datapath #(.RING_DEPTH(RING_DEPTH)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_operation      (in_operation),
    .in_buf_addr       (in_buf_addr),
    .in_buf_length     (in_buf_length),
    .in_packet_length  (in_packet_length),
    .in_endpoint_busy  (in_endpoint_busy),
    .out_valid         (out_valid),
    .out_accepted      (out_accepted),
    .out_pop_valid     (out_pop_valid),
    .out_popped_length (out_popped_length),
    .out_xfer_valid    (out_xfer_valid),
    .out_xfer_addr     (out_xfer_addr),
    .out_xfer_length   (out_xfer_length),
    .out_frame_done    (out_frame_done),
    .out_nak_enable    (out_nak_enable)
  );

  `UBFS_ASSERT_NEXT(a_load_then_exec, cmd.load, cmd.exec && busy, "accepted word not executed")
  `UBFS_ASSERT_NEXT(a_exec_one_cycle, cmd.exec, !busy && out_valid, "execute not followed by result")
  `UBFS_ASSERT_NEXT(a_no_spurious_result, !cmd.exec, !out_valid, "result without execute")
  `UBFS_ASSERT(a_done_has_xfer, !(out_valid && out_frame_done) || out_xfer_valid, "frame done without transfer")

endmodule

`default_nettype wire
